/* hdl/mse_pkg.sv */
// Shared constants, widths and controller/datapath command and status types
// for the mean squared error loss block. No dependencies.
package mse_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int DATA_WIDTH   = 16;

    localparam int DIFF_W      = DATA_WIDTH + 1;
    localparam int GRAD_W      = DIFF_W + 1;
    localparam int SQ_W        = 2 * DATA_WIDTH;
    localparam int CNT_W       = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W       = SQ_W + $clog2(MAX_ELEMENTS);
    localparam int MEAN_W      = 32;
    localparam int STEP_W      = $clog2(SUM_W + 1);
    localparam int IN_DATA_W   = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((GRAD_W + MEAN_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    typedef struct packed {
        logic capture;
        logic square;
        logic accumulate;
        logic emit_item;
        logic div_start;
        logic emit_mean;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
        logic div_busy;
    } t_status;

endpackage

/* hdl/mse_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean computation.
// Depends on mse_pkg.
module mse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mse_pkg::SUM_W-1:0]  i_dividend,
    input  logic [mse_pkg::CNT_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [mse_pkg::SUM_W-1:0]  o_quotient
);
    import mse_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    w_rem_sh;
    logic [CNT_W+1:0]  w_trial;
    logic              w_borrow;

    assign w_rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_borrow = w_trial[CNT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], ~w_borrow};
            r_rem <= w_borrow ? w_rem_sh[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = (r_div == '0) ? '0 : r_quo;

endmodule

/* hdl/mse_ctrl.sv */
// Sequencing state machine: capture, square, accumulate, divide, emit.
// Depends on mse_pkg.
module mse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  mse_pkg::t_status i_status,
    output mse_pkg::t_cmd    o_cmd
);
    import mse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACC,
        S_START,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                w_cmd.square = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                if (i_status.last) begin
                    w_cmd.accumulate = 1'b1;
                    n_state          = S_START;
                end else if (i_status.out_free) begin
                    w_cmd.accumulate = 1'b1;
                    w_cmd.emit_item  = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_START: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    w_cmd.emit_mean = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd           = w_cmd;
    assign o_s_axis_tready = (r_state == S_IDLE);

endmodule

/* hdl/mse_datapath.sv */
// Difference, square, accumulator, element count and output register.
// Depends on mse_pkg and mse_div.
module mse_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mse_pkg::t_cmd                   i_cmd,
    output mse_pkg::t_status                o_status,
    input  logic [mse_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [mse_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic [mse_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);
    import mse_pkg::*;

    logic signed [DATA_WIDTH-1:0] w_true;
    logic signed [DATA_WIDTH-1:0] w_pred;
    logic signed [DIFF_W-1:0]     w_diff;
    logic signed [2*DIFF_W-1:0]   w_prod;
    logic signed [DIFF_W-1:0]     r_diff;
    logic                         r_last;
    logic [SQ_W-1:0]              r_sq;
    logic [SUM_W-1:0]             r_sum;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_ovf;
    logic                         w_full;
    logic                         w_div_busy;
    logic [SUM_W-1:0]             w_quotient;
    logic                         r_out_valid;
    logic [GRAD_W-1:0]            r_grad;
    logic [MEAN_W-1:0]            r_mean;
    logic                         r_loss_valid;
    logic                         r_out_ovf;

    assign w_true = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign w_pred = i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign w_diff = $signed({w_pred[DATA_WIDTH-1], w_pred})
                  - $signed({w_true[DATA_WIDTH-1], w_true});
    assign w_prod = r_diff * r_diff;
    assign w_full = (r_cnt == CNT_W'(MAX_ELEMENTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_diff <= w_diff;
            r_last <= i_s_axis_tlast;
        end
        if (i_cmd.square) begin
            r_sq <= w_prod[SQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.emit_mean) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accumulate) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_sum <= r_sum + SUM_W'(r_sq);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    mse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_item || i_cmd.emit_mean) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_item) begin
            r_grad       <= {r_diff, 1'b0};
            r_mean       <= '0;
            r_loss_valid <= 1'b0;
            r_out_ovf    <= r_ovf | w_full;
        end else if (i_cmd.emit_mean) begin
            r_grad       <= {r_diff, 1'b0};
            r_mean       <= MEAN_W'(w_quotient);
            r_loss_valid <= 1'b1;
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = ~r_out_valid | i_m_axis_tready;
    assign o_status.div_busy = w_div_busy;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_mean, r_grad});
    assign o_m_axis_tuser  = {r_out_ovf, r_loss_valid};

endmodule

/* hdl/mean_squared_error_loss.sv */
// Mean squared error loss and gradient, top level.
// Depends on mse_pkg, mse_ctrl and mse_datapath.
//
// Each input transfer carries one target/prediction pair (signed Q4.12) and
// tlast on the final element of a matrix. Every transfer yields one output
// transfer with the gradient 2*(prediction-target) at Q.12 scale; the one for
// the final element also carries the mean squared difference at Q8.24 scale
// (sum divided by count, truncated) and loss_valid, after which the sum, the
// count and the overflow flag clear. Beyond 4096 elements per matrix the
// extra elements are left out of the mean and overflow is raised until the
// matrix ends. An ordinary element passes capture, square through the
// multiplier and accumulate; the final element then also waits for the
// 44-step bit-serial divider that forms the mean. Intake pauses until each
// element is done and while a finished result waits in the output register.
module mean_squared_error_loss (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [15:0] true_value, [31:16] predicted_value
    input  logic [mse_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // last_element
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [17:0] gradient, [49:18] mean_loss, zero fill above
    output logic [mse_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [0] loss_valid, [1] overflow
    output logic [mse_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);
    import mse_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mse_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    mse_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
